// ===== rtl/core/swm_pkg.sv =====
// Shared types and constants for the sliding window minimum block.
`default_nettype none

package swm_pkg;

	// Q1.16 weight and result widths.
	localparam int WEIGHT_W = 17;
	localparam int IDX_W    = 16;
	localparam int CFG_W    = 7;

	// The value 1.0 in Q1.16, the start value of every window.
	localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'h10000;

	// Largest start index that the result can show.
	localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;

	// Control that every cell of the chain sees in the same cycle.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
// One cell of the min chain: holds the minimum of 1.0 and the last weights to its depth.
`default_nettype none

module swm_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire swm_pkg::cell_ctrl_t   ctrl,
	input  wire [swm_pkg::WEIGHT_W-1:0] x,
	input  wire [swm_pkg::WEIGHT_W-1:0] prev,
	input  wire                        sel,
	output logic [swm_pkg::WEIGHT_W-1:0] value,
	output logic [swm_pkg::WEIGHT_W-1:0] tap
);
	import swm_pkg::*;

	logic [WEIGHT_W-1:0] value_q;

	// On each transfer the cell takes the smaller of its neighbor and the new weight.
	// The end of a sequence returns it to 1.0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= Q16_ONE;
		end else if (ctrl.shift) begin
			if (ctrl.clear) begin
				value_q <= Q16_ONE;
			end else begin
				value_q <= (x < prev) ? x : prev;
			end
		end
	end

	assign value = value_q;

	// The selected cell drives the shared tap; all others drive zero.
	assign tap = value_q & {WEIGHT_W{sel}};

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_minimum.sv =====
// Sliding window minimum over a stream of Q1.16 weights.
//
// Weights enter on s_axis, one per transfer, with tlast on the final weight of
// a sequence. For each window start the block sends on m_axis the minimum of
// 1.0 and the window_width weights from that start, with the start index.
// The window width is written on the cfg channel between transfers.
// Once window_width weights of a sequence have arrived, each weight gives one
// result, in the cycle after its transfer, from a single output register.
// A weight that closes a sequence with a width of w above 1 is followed by
// w-1 fill results of 1.0 (tuser set); the input is held off until the last
// of them is loaded. Otherwise one weight is taken per cycle unless m_axis
// stalls; the output register sets the rate, one result per cycle when ready.
// A sequence shorter than the window gives no results.
// When m_axis stalls, the waiting result holds and s_axis_tready drops.
// Reset sets the width to 1, every chain cell to 1.0 and the position to 0.
`default_nettype none

module sliding_window_minimum #(
	parameter int MAX_WINDOW = 64,
	parameter int MAX_LENGTH = 65536
) (
	input  wire        clk,
	input  wire        arst_n,
	// Configuration: window_width.
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [6:0]  cfg_data,
	// Input stream.
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [23:0] s_axis_tdata,   // [16:0] weight, [23:17] zero
	input  wire        s_axis_tlast,   // last_in_sequence
	// Output stream.
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [16:0] min_value, [32:17] start_index, [39:33] zero
	output logic       m_axis_tuser,   // tail_fill
	output logic       m_axis_tlast    // last_of_run
);
	import swm_pkg::*;

	localparam int WW = $clog2(MAX_WINDOW + 1);
	localparam int PW = $clog2(MAX_LENGTH + 1);

	// Saturate a position to the start index range.
	function automatic logic [IDX_W-1:0] sat_idx(input logic [PW:0] v);
		if (v > (PW+1)'(IDX_MAX)) begin
			sat_idx = IDX_MAX;
		end else begin
			sat_idx = IDX_W'(v);
		end
	endfunction

	logic [CFG_W-1:0]    width_q;
	logic [WW-1:0]       w_eff;
	logic [PW-1:0]       pos_q;
	logic [PW:0]         pos_plus;
	logic [PW:0]         start_pos;
	logic                emit;
	logic                in_fire;
	logic                out_free;
	logic                load_fill;
	logic                load_item;
	logic                fill_busy_q;
	logic [WW-1:0]       fill_left_q;
	logic [PW:0]         fill_idx_q;
	logic                out_valid_q;
	logic [WEIGHT_W-1:0] out_value_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_fill_q;
	logic                out_last_q;
	logic [WEIGHT_W-1:0] x;
	logic [WEIGHT_W-1:0] tap_or;
	logic [WEIGHT_W-1:0] prev_tap;
	logic [WEIGHT_W-1:0] item_min;
	cell_ctrl_t          ctrl;

	logic [WEIGHT_W-1:0] cell_value [MAX_WINDOW];
	logic [WEIGHT_W-1:0] cell_tap   [MAX_WINDOW];

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			width_q <= cfg_data;
		end
	end

	// Width in use: zero counts as one, large values stop at the chain length.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WINDOW) begin
			w_eff = WW'(MAX_WINDOW);
		end else begin
			w_eff = WW'(width_q);
		end
	end

	// Handshake and the decisions for this cycle.
	assign x             = s_axis_tdata[WEIGHT_W-1:0];
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !fill_busy_q && out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign pos_plus      = {1'b0, pos_q} + (PW+1)'(1);
	assign emit          = pos_plus >= (PW+1)'(w_eff);
	assign start_pos     = pos_plus - (PW+1)'(w_eff);
	assign load_fill     = out_free && fill_busy_q;
	assign load_item     = in_fire && emit;

	assign ctrl.shift = in_fire;
	assign ctrl.clear = s_axis_tlast;

	// The chain of min cells; cell d holds the minimum over the last d+1 weights.
	for (genvar d = 0; d < MAX_WINDOW; d++) begin : g_cell
		logic                sel;
		logic [WEIGHT_W-1:0] prev;

		assign sel = ((WW+1)'(d) + (WW+1)'(2)) == {1'b0, w_eff};

		if (d == 0) begin : g_head
			assign prev = Q16_ONE;
		end else begin : g_link
			assign prev = cell_value[d-1];
		end

		swm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.x      (x),
			.prev   (prev),
			.sel    (sel),
			.value  (cell_value[d]),
			.tap    (cell_tap[d])
		);
	end

	// Combine the taps; only the cell at depth width-2 drives one.
	always_comb begin
		tap_or = '0;
		for (int d = 0; d < MAX_WINDOW; d++) begin
			tap_or = tap_or | cell_tap[d];
		end
	end

	assign prev_tap = (w_eff == WW'(1)) ? Q16_ONE : tap_or;
	assign item_min = (x < prev_tap) ? x : prev_tap;

	// Position count, fill sequencing and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_busy_q <= 1'b0;
			fill_left_q <= '0;
			fill_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (s_axis_tlast) begin
					pos_q <= '0;
				end else if (pos_q < PW'(MAX_LENGTH)) begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (load_fill) begin
				fill_idx_q  <= fill_idx_q + (PW+1)'(1);
				fill_left_q <= fill_left_q - WW'(1);
				if (fill_left_q == WW'(1)) begin
					fill_busy_q <= 1'b0;
				end
			end else if (load_item && s_axis_tlast && (w_eff != WW'(1))) begin
				fill_busy_q <= 1'b1;
				fill_left_q <= w_eff - WW'(1);
				fill_idx_q  <= start_pos + (PW+1)'(1);
			end
			if (out_free) begin
				out_valid_q <= load_fill || load_item;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load_fill) begin
			out_value_q <= Q16_ONE;
			out_idx_q   <= sat_idx(fill_idx_q);
			out_fill_q  <= 1'b1;
			out_last_q  <= fill_left_q == WW'(1);
		end else if (load_item) begin
			out_value_q <= item_min;
			out_idx_q   <= sat_idx(start_pos);
			out_fill_q  <= 1'b0;
			out_last_q  <= s_axis_tlast && (w_eff == WW'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_idx_q, out_value_q};
	assign m_axis_tuser  = out_fill_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/swm_checker.sv =====
// Port-level assertions for the sliding window minimum block, with their bind.
`default_nettype none

module swm_port_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata,
	input wire        m_axis_tuser,
	input wire        m_axis_tlast
);
	import swm_pkg::*;

	// A stalled result keeps its contents.
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// No result exceeds 1.0.
	a_cap : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[WEIGHT_W-1:0] <= Q16_ONE)
		else $error("result above 1.0");

	// Fill results always carry 1.0.
	a_fill_one : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[WEIGHT_W-1:0] == Q16_ONE)
		else $error("fill result not 1.0");

	// While more fill results are due, no new weight is taken.
	a_fill_block : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken during tail fill");

endmodule

bind sliding_window_minimum swm_port_checker u_swm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
